[rtl/core/tccw_pkg.sv]
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants of the text console cursor writer: screen
// geometry, control byte codes, character classes and queue entries.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

    // screen geometry
    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int SCREENS      = 4;
    localparam int BUF_CELLS    = COLUMNS * ROWS * SCREENS;
    localparam int SCROLL_LIMIT = (ROWS - 2) * SCREENS;

    // field widths
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int COORD_W = 7;
    localparam int INDEX_W = 13;
    localparam int POS_W   = 15;

    // tab stops fall on multiples of this
    localparam int TAB_STEP = 8;

    // control byte codes
    localparam logic [CHAR_W-1:0] CHAR_BS = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_HT = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;

    // attribute used when the caller gives zero
    localparam logic [ATTR_W-1:0] ATTR_DEFAULT = 8'h0F;

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // character classes
    typedef enum logic [4:0] {
        CLS_PRINT = 5'b00001,
        CLS_BS    = 5'b00010,
        CLS_TAB   = 5'b00100,
        CLS_CR    = 5'b01000,
        CLS_LF    = 5'b10000
    } t_cls;

    // classified item as held in the queue
    typedef struct packed {
        t_cls              cls;
        logic [CHAR_W-1:0] char_code;
        logic [ATTR_W-1:0] attr;
        logic              eos;
    } t_item;

    // one result transaction
    typedef struct packed {
        logic               write_enable;
        logic [INDEX_W-1:0] cell_index;
        logic [CHAR_W-1:0]  cell_char;
        logic [ATTR_W-1:0]  cell_attr;
        logic               clear_all;
        logic               flush_request;
        logic [COORD_W-1:0] scroll_row;
        logic [COORD_W-1:0] cursor_col;
        logic [COORD_W-1:0] cursor_row;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/text_console_cursor_writer_core.sv]
// Path: an accepted input transaction passes the front stage register, the queue
// and the output register, in that order, before its result is on the output ports.
// Throughput: one character per cycle while pop keeps up; the back's cursor update
// and the output register set that rate, the 4-entry queue absorbs stalls.
// Reset (synchronous, active low) zeroes cursor, scroll row and modified flag
// and empties the front stage, the queue and the output register.
// ----------------------------------------------------------------------------
// text_console_cursor_writer_core
// Text console cursor writer: turns a character stream into cell writes,
// cursor moves, scroll, clear and flush requests over a text framebuffer.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_writer_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [tccw_pkg::CHAR_W-1:0]  i_char_code,
    input  wire logic [tccw_pkg::ATTR_W-1:0]  i_attribute,
    input  wire logic                         i_end_of_string,
    output logic                              empty,
    input  wire logic                         pop,
    output logic                              o_write_enable,
    output logic [tccw_pkg::INDEX_W-1:0]      o_cell_index,
    output logic [tccw_pkg::CHAR_W-1:0]       o_cell_char,
    output logic [tccw_pkg::ATTR_W-1:0]       o_cell_attr,
    output logic                              o_clear_all,
    output logic                              o_flush_request,
    output logic [tccw_pkg::COORD_W-1:0]      o_scroll_row_out,
    output logic [tccw_pkg::COORD_W-1:0]      o_cursor_col_out,
    output logic [tccw_pkg::COORD_W-1:0]      o_cursor_row_out
);

    logic              q_wr;
    logic              q_full;
    logic              q_rd;
    logic              q_empty;
    tccw_pkg::t_item   q_wr_item;
    tccw_pkg::t_item   q_rd_item;
    logic              res_valid;
    tccw_pkg::t_result res;

    // front: accept and classify
    tccw_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_char_code     (i_char_code),
        .i_attribute     (i_attribute),
        .i_end_of_string (i_end_of_string),
        .o_q_wr          (q_wr),
        .o_q_item        (q_wr_item),
        .i_q_full        (q_full)
    );

    // decoupling queue
    tccw_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_item (q_wr_item),
        .o_full    (q_full),
        .i_rd      (q_rd),
        .o_rd_item (q_rd_item),
        .o_empty   (q_empty)
    );

    // back: cursor update and result register
    tccw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (q_rd_item),
        .i_q_empty   (q_empty),
        .o_q_rd      (q_rd),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (pop)
    );

    // result ports
    assign empty            = !res_valid;
    assign o_write_enable   = res.write_enable;
    assign o_cell_index     = res.cell_index;
    assign o_cell_char      = res.cell_char;
    assign o_cell_attr      = res.cell_attr;
    assign o_clear_all      = res.clear_all;
    assign o_flush_request  = res.flush_request;
    assign o_scroll_row_out = res.scroll_row;
    assign o_cursor_col_out = res.cursor_col;
    assign o_cursor_row_out = res.cursor_row;

endmodule

`default_nettype wire

[rtl/core/tccw_front.sv]
// ----------------------------------------------------------------------------
// tccw_front
// Accepts input transactions, classifies the character byte, substitutes the
// default attribute and holds the item in a stage register until the queue
// takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [tccw_pkg::CHAR_W-1:0] i_char_code,
    input  wire logic [tccw_pkg::ATTR_W-1:0] i_attribute,
    input  wire logic                        i_end_of_string,
    output logic                             o_q_wr,
    output tccw_pkg::t_item                  o_q_item,
    input  wire logic                        i_q_full
);

    logic            r_valid;
    tccw_pkg::t_item r_item;
    tccw_pkg::t_item n_item;
    logic            take;

    // stage is busy only while holding an item the queue cannot take
    assign full   = r_valid && i_q_full;
    assign take   = push && !full;
    assign o_q_wr = r_valid && !i_q_full;
    assign o_q_item = r_item;

    // classify the incoming byte
    always_comb begin
        priority if (i_char_code == tccw_pkg::CHAR_BS) begin
            n_item.cls = tccw_pkg::CLS_BS;
        end else if (i_char_code == tccw_pkg::CHAR_HT) begin
            n_item.cls = tccw_pkg::CLS_TAB;
        end else if (i_char_code == tccw_pkg::CHAR_CR) begin
            n_item.cls = tccw_pkg::CLS_CR;
        end else if (i_char_code == tccw_pkg::CHAR_LF) begin
            n_item.cls = tccw_pkg::CLS_LF;
        end else begin
            n_item.cls = tccw_pkg::CLS_PRINT;
        end
        n_item.char_code = i_char_code;
        n_item.attr      = (i_attribute != '0) ? i_attribute : tccw_pkg::ATTR_DEFAULT;
        n_item.eos       = i_end_of_string;
    end

    // stage valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_q_wr) begin
            r_valid <= 1'b0;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

[rtl/core/tccw_queue.sv]
// ----------------------------------------------------------------------------
// tccw_queue
// Short first-in first-out queue of classified items between the front and
// the back, so that each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  wire tccw_pkg::t_item i_wr_item,
    output logic                 o_full,
    input  wire logic            i_rd,
    output tccw_pkg::t_item      o_rd_item,
    output logic                 o_empty
);

    tccw_pkg::t_item                 r_mem [tccw_pkg::QUEUE_DEPTH];
    logic [tccw_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [tccw_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [tccw_pkg::QCNT_W-1:0]     r_count;
    logic                            wr_ok;
    logic                            rd_ok;

    assign o_full    = (r_count == tccw_pkg::QCNT_W'(tccw_pkg::QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign wr_ok     = i_wr && !o_full;
    assign rd_ok     = i_rd && !o_empty;
    assign o_rd_item = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_ok) begin
                r_wr_ptr <= (r_wr_ptr == tccw_pkg::QPTR_W'(tccw_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_ok) begin
                r_rd_ptr <= (r_rd_ptr == tccw_pkg::QPTR_W'(tccw_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({wr_ok, rd_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

endmodule

`default_nettype wire

[rtl/core/tccw_back.sv]
// ----------------------------------------------------------------------------
// tccw_back
// Carries out classified items: keeps the cursor, scroll row and modified
// flag, forms the cell write, wrap, scroll, clear and flush, and holds the
// result in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tccw_pkg::t_item i_item,
    input  wire logic            i_q_empty,
    output logic                 o_q_rd,
    output logic                 o_res_valid,
    output tccw_pkg::t_result    o_res,
    input  wire logic            i_res_take
);

    logic [tccw_pkg::COORD_W-1:0] r_col;
    logic [tccw_pkg::COORD_W-1:0] r_row;
    logic [tccw_pkg::COORD_W-1:0] r_scroll;
    logic                         r_mod;
    logic                         r_out_valid;
    tccw_pkg::t_result            r_out;

    logic [tccw_pkg::COORD_W-1:0] n_col;
    logic [tccw_pkg::COORD_W-1:0] n_row;
    logic [tccw_pkg::COORD_W-1:0] n_scroll;
    logic                         n_mod;
    tccw_pkg::t_result            n_out;

    logic [tccw_pkg::POS_W-1:0]   pos;
    logic                         in_buf;
    logic [tccw_pkg::COORD_W:0]   col_t;
    logic [tccw_pkg::COORD_W-1:0] row_t;
    logic [tccw_pkg::COORD_W-1:0] scroll_t;
    logic                         mod_t;
    logic                         step;

    // pull from the queue whenever the output slot frees up
    assign step        = !i_q_empty && (!r_out_valid || i_res_take);
    assign o_q_rd      = step;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // cell position under the cursor
    assign pos    = tccw_pkg::POS_W'(r_row) * tccw_pkg::POS_W'(tccw_pkg::COLUMNS)
                  + tccw_pkg::POS_W'(r_col);
    assign in_buf = (pos < tccw_pkg::POS_W'(tccw_pkg::BUF_CELLS));

    // cursor update for one item
    always_comb begin
        col_t = {1'b0, r_col};
        row_t = r_row;
        mod_t = r_mod;
        n_out = '0;

        unique case (i_item.cls)
            tccw_pkg::CLS_BS: begin
                if (r_col != '0) begin
                    col_t = {1'b0, r_col - 1'b1};
                end
            end
            tccw_pkg::CLS_TAB: begin
                col_t = ({1'b0, r_col} + (tccw_pkg::COORD_W+1)'(tccw_pkg::TAB_STEP))
                      & ~(tccw_pkg::COORD_W+1)'(tccw_pkg::TAB_STEP - 1);
            end
            tccw_pkg::CLS_CR: begin
                col_t = '0;
            end
            tccw_pkg::CLS_LF: begin
                mod_t = 1'b1;
                col_t = '0;
                row_t = r_row + 1'b1;
            end
            default: begin
                if (in_buf) begin
                    n_out.write_enable = 1'b1;
                    n_out.cell_index   = pos[tccw_pkg::INDEX_W-1:0];
                    n_out.cell_char    = i_item.char_code;
                    n_out.cell_attr    = i_item.attr;
                    mod_t              = 1'b1;
                end
                col_t = {1'b0, r_col} + 1'b1;
            end
        endcase

        // line wrap
        if (col_t >= (tccw_pkg::COORD_W+1)'(tccw_pkg::COLUMNS)) begin
            n_col = '0;
            row_t = row_t + 1'b1;
        end else begin
            n_col = col_t[tccw_pkg::COORD_W-1:0];
        end

        // scroll when the cursor row passes the scroll row plus ROWS
        scroll_t = r_scroll;
        if ((tccw_pkg::COORD_W+1)'(tccw_pkg::ROWS) + {1'b0, r_scroll} < {1'b0, row_t}) begin
            scroll_t = r_scroll + 1'b1;
        end

        // clear the buffer at the scroll limit
        n_row    = row_t;
        n_scroll = scroll_t;
        if ({1'b0, scroll_t} >= (tccw_pkg::COORD_W+1)'(tccw_pkg::SCROLL_LIMIT)) begin
            n_out.clear_all = 1'b1;
            n_scroll        = '0;
            n_row           = '0;
        end

        // flush at end of string when the modified flag is set
        n_mod = mod_t;
        if (i_item.eos && mod_t) begin
            n_out.flush_request = 1'b1;
            n_mod               = 1'b0;
        end

        n_out.scroll_row = n_scroll;
        n_out.cursor_col = n_col;
        n_out.cursor_row = n_row;
    end

    // cursor state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_scroll    <= '0;
            r_mod       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_col    <= n_col;
                r_row    <= n_row;
                r_scroll <= n_scroll;
                r_mod    <= n_mod;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_res_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire
